>>> rtl/binary_interior_pixel_removal_core_macros.svh
// Assertion macros shared by the boundary extraction RTL.
// Users must have clk and active-low synchronous rst_n in scope.
`ifndef BINARY_INTERIOR_PIXEL_REMOVAL_CORE_MACROS_SVH
`define BINARY_INTERIOR_PIXEL_REMOVAL_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BIPR_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define BIPR_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/bipr_pkg.sv
// Shared types and constants for the binary boundary extraction core.
// No dependencies; used by binary_interior_pixel_removal_core.
package bipr_pkg;

  localparam int unsigned PIX_W      = 8;
  localparam int unsigned FW_W       = 11;
  localparam int unsigned FH_W       = 13;
  localparam int unsigned ROW_W      = 14;
  localparam int unsigned WIN        = 3;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 13;

  localparam logic [FW_W-1:0]  FRAME_WIDTH_RST     = 11'd640;
  localparam logic [FH_W-1:0]  FRAME_HEIGHT_RST    = 13'd480;
  localparam logic [PIX_W-1:0] LEVEL_THRESHOLD_RST = 8'd250;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_FRAME_WIDTH     = 2'd0,
    REG_FRAME_HEIGHT    = 2'd1,
    REG_LEVEL_THRESHOLD = 2'd2
  } cfg_reg_t;

  typedef logic [PIX_W-1:0] pix_t;

  // One result word as it sits in the output or skid register.
  typedef struct packed {
    pix_t value;
    logic last;
  } result_t;

endpackage

>>> rtl/bipr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; used for the line buffers of the boundary extraction core.
module bipr_ram #(
  parameter int unsigned DATA_W = 16,
  parameter int unsigned DEPTH  = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [DATA_W-1:0]        wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [DATA_W-1:0]        rdata
);

  logic [DATA_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

>>> rtl/binary_interior_pixel_removal_core.sv
// Binary boundary extraction over a 3x3 window: top level of the core.
// Depends on bipr_pkg, bipr_ram and binary_interior_pixel_removal_core_macros.svh.
//
//  Channel | Direction | Word contents
//  --------+-----------+---------------------------------------------------
//  in_*    | sink      | tdata[7:0] pixel_value, tuser flush
//  out_*   | source    | tdata[7:0] out_value, tlast frame_last
//  cfg_*   | sink      | write enable, register index, write data
//
// The core takes one word per clock while in_tready is high. A result enters the
// output register, or the skid register while the output side stalls, as the word
// completing its window is accepted; in the stream it trails the input by one line
// plus one pixel, and width+1 flush words drain each frame's tail. The line buffer
// read for the next word is issued ahead, so the input is held off in the first
// cycle after reset and after each configuration write. A skid register behind the
// output register keeps the input flowing for one more result during a stall.
`include "binary_interior_pixel_removal_core_macros.svh"

module binary_interior_pixel_removal_core #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // Input stream.
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [7:0]                         in_tdata,   // [7:0] pixel_value
  input  logic                               in_tuser,   // [0] flush
  // Result stream.
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [7:0]                         out_tdata,  // [7:0] out_value
  output logic                               out_tlast,
  // Configuration writes.
  input  logic                               cfg_we,
  input  logic [bipr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bipr_pkg::CFG_DATA_W-1:0]    cfg_data
);

  localparam int unsigned AW    = $clog2(MAX_WIDTH);
  localparam int unsigned WW    = AW + 1;
  localparam int unsigned ROW_W = bipr_pkg::ROW_W;
  localparam int unsigned WIN   = bipr_pkg::WIN;

  // Configuration registers.
  logic [bipr_pkg::FW_W-1:0] frame_width_r;
  logic [bipr_pkg::FH_W-1:0] frame_height_r;
  bipr_pkg::pix_t            level_threshold_r;
  logic                      hold_r;

  // Position of the next input word, window and output buffering.
  logic [AW-1:0]    col_r, col_nxt;
  logic [ROW_W-1:0] row_r, row_nxt;
  bipr_pkg::pix_t   win_r   [WIN][WIN];
  bipr_pkg::pix_t   win_nxt [WIN][WIN];
  logic             out_valid_r, skid_valid_r;
  bipr_pkg::result_t out_data_r, skid_data_r;

  logic             in_acc, out_pop;
  logic [WW-1:0]    eff_w;
  logic [ROW_W-1:0] eff_h;
  bipr_pkg::pix_t   px;
  logic             wrap0, wrap1;
  logic [AW-1:0]    x, cc, rd_addr;
  logic [WW-1:0]    x1;
  logic [ROW_W-1:0] y, y2, cr_u;
  logic signed [ROW_W:0] cr;
  logic             res_valid, res_last, all_bright;
  logic             top_ok, bot_ok, left_ok, right_ok;
  bipr_pkg::pix_t   centre;
  bipr_pkg::result_t res;
  logic [2*bipr_pkg::PIX_W-1:0] line_q, line_wr;

  assign in_acc    = in_tvalid && in_tready;
  assign out_pop   = out_valid_r && out_tready;
  assign in_tready = !skid_valid_r && !hold_r;

  // Register values are clamped where they are used.
  always_comb begin
    if (frame_width_r < 11'd3) begin
      eff_w = WW'(3);
    end else if (32'(frame_width_r) > 32'(MAX_WIDTH)) begin
      eff_w = WW'(MAX_WIDTH);
    end else begin
      eff_w = WW'(frame_width_r);
    end
    eff_h = (frame_height_r < 13'd3) ? ROW_W'(3) : ROW_W'(frame_height_r);
  end

  // Configuration port; a write also blocks input in the cycle after it so the line
  // buffer read can be reissued with the new width.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_width_r     <= bipr_pkg::FRAME_WIDTH_RST;
      frame_height_r    <= bipr_pkg::FRAME_HEIGHT_RST;
      level_threshold_r <= bipr_pkg::LEVEL_THRESHOLD_RST;
      hold_r            <= 1'b1;
    end else begin
      hold_r <= cfg_we;
      if (cfg_we) begin
        unique case (bipr_pkg::cfg_reg_t'(cfg_index))
          bipr_pkg::REG_FRAME_WIDTH:     frame_width_r     <= cfg_data[bipr_pkg::FW_W-1:0];
          bipr_pkg::REG_FRAME_HEIGHT:    frame_height_r    <= cfg_data[bipr_pkg::FH_W-1:0];
          bipr_pkg::REG_LEVEL_THRESHOLD: level_threshold_r <= cfg_data[7:0];
          default: ;
        endcase
      end
    end
  end

  // Position of the current word. A stored column at or past the width (possible
  // only after the width was reduced) wraps to the start of the next row.
  always_comb begin
    px    = in_tuser ? '0 : in_tdata;
    wrap0 = {1'b0, col_r} >= eff_w;
    x     = wrap0 ? '0 : col_r;
    y     = row_r + ROW_W'(wrap0);

    // Window centre sits one column and one row behind the incoming word.
    if (x != '0) begin
      cr = $signed({1'b0, y}) - 15'sd1;
      cc = x - AW'(1);
    end else begin
      cr = $signed({1'b0, y}) - 15'sd2;
      cc = AW'(eff_w - WW'(1));
    end
    cr_u      = cr[ROW_W-1:0];
    res_valid = !cr[ROW_W] && (cr_u < eff_h);
    res_last  = (cr_u == eff_h - ROW_W'(1)) && ({1'b0, cc} == eff_w - WW'(1));

    // Advance to the following word; a row count past the frame plus one line
    // restarts the frame.
    x1    = {1'b0, x} + WW'(1);
    wrap1 = x1 >= eff_w;
    y2    = y + ROW_W'(wrap1);
  end

  always_comb begin
    col_nxt = col_r;
    row_nxt = row_r;
    if (in_acc) begin
      col_nxt = wrap1 ? '0 : x1[AW-1:0];
      row_nxt = y2;
      if ((y2 > eff_h + ROW_W'(1)) || (res_valid && res_last)) begin
        col_nxt = '0;
        row_nxt = '0;
      end
    end
    if (!rst_n) begin
      col_nxt = '0;
      row_nxt = '0;
    end
    rd_addr = ({1'b0, col_nxt} >= eff_w) ? '0 : col_nxt;
  end

  // Both line buffers share one RAM word: upper byte newer line, lower byte older.
  // The read for the next word's column is issued while the current word is taken.
  assign line_wr = {px, line_q[2*bipr_pkg::PIX_W-1:bipr_pkg::PIX_W]};

  bipr_ram #(
    .DATA_W (2 * bipr_pkg::PIX_W),
    .DEPTH  (MAX_WIDTH)
  ) u_line_ram (
    .clk   (clk),
    .we    (in_acc),
    .waddr (x),
    .wdata (line_wr),
    .raddr (rd_addr),
    .rdata (line_q)
  );

  // Window shifts left and takes the new column: rows y-2, y-1 and y.
  always_comb begin
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < WIN - 1; c++) begin
        win_nxt[r][c] = win_r[r][c+1];
      end
    end
    win_nxt[0][WIN-1] = line_q[bipr_pkg::PIX_W-1:0];
    win_nxt[1][WIN-1] = line_q[2*bipr_pkg::PIX_W-1:bipr_pkg::PIX_W];
    win_nxt[2][WIN-1] = px;
  end

  // Interior test: neighbors outside the frame are ignored.
  always_comb begin
    logic row_ok [WIN];
    logic col_ok [WIN];
    top_ok   = cr_u != '0;
    bot_ok   = cr_u < eff_h - ROW_W'(1);
    left_ok  = cc != '0;
    right_ok = {1'b0, cc} < eff_w - WW'(1);
    row_ok[0] = top_ok;
    row_ok[1] = 1'b1;
    row_ok[2] = bot_ok;
    col_ok[0] = left_ok;
    col_ok[1] = 1'b1;
    col_ok[2] = right_ok;
    all_bright = 1'b1;
    for (int r = 0; r < WIN; r++) begin
      for (int c = 0; c < WIN; c++) begin
        if (row_ok[r] && col_ok[c] && (win_nxt[r][c] < level_threshold_r)) begin
          all_bright = 1'b0;
        end
      end
    end
    centre    = win_nxt[1][1];
    res.value = ((centre > level_threshold_r) && all_bright) ? '0 : centre;
    res.last  = res_last;
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
      for (int r = 0; r < WIN; r++) begin
        for (int c = 0; c < WIN; c++) begin
          win_r[r][c] <= '0;
        end
      end
    end else begin
      if (in_acc) begin
        win_r <= win_nxt;
      end
      if (skid_valid_r) begin
        if (out_pop) begin
          skid_valid_r <= 1'b0;
        end
      end else if (in_acc && res_valid) begin
        if (out_valid_r && !out_tready) begin
          skid_valid_r <= 1'b1;
        end else begin
          out_valid_r <= 1'b1;
        end
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
    col_r <= col_nxt;
    row_r <= row_nxt;
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (out_pop) begin
        out_data_r <= skid_data_r;
      end
    end else if (in_acc && res_valid) begin
      if (out_valid_r && !out_tready) begin
        skid_data_r <= res;
      end else begin
        out_data_r <= res;
      end
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r.value;
  assign out_tlast  = out_data_r.last;

  `BIPR_ASSERT_NOW(a_skid_behind_out, skid_valid_r, out_valid_r, "skid full while output empty")
  `BIPR_ASSERT_NEXT(a_cfg_blocks_input, cfg_we, !in_tready, "input taken right after cfg write")
  `BIPR_ASSERT_NEXT(a_last_restarts, in_acc && res_valid && res_last, (col_r == '0) && (row_r == '0), "frame did not restart after last")
  `BIPR_ASSERT_NEXT(a_out_drains, out_pop && !skid_valid_r && !(in_acc && res_valid), !out_valid_r, "output stayed valid after drain")

endmodule

>>> tb/tb_binary_interior_pixel_removal_core.sv
// Testbench for binary_interior_pixel_removal_core: streams 8-bit frames through the core and
// checks every result word against a cycle-free boundary extraction predictor kept here.
// Depends on bipr_pkg and the core RTL only.
`timescale 1ns / 1ps

module tb_binary_interior_pixel_removal_core;

  localparam int unsigned LINE_DEPTH   = 1024;
  localparam int unsigned SETTLE       = 8;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned RANDOM_WORDS = 340;
  localparam int unsigned CYCLE_LIMIT  = 1000000;
  localparam int unsigned MAX_REPORTS  = 10;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic              in_tvalid = 1'b0;
  logic              in_tready;
  logic [7:0]        in_tdata = '0;
  logic              in_tuser = 1'b0;
  logic              out_tvalid;
  logic              out_tready = 1'b0;
  logic [7:0]        out_tdata;
  logic              out_tlast;
  logic              cfg_we = 1'b0;
  logic [bipr_pkg::CFG_IDX_W-1:0]  cfg_index = '0;
  logic [bipr_pkg::CFG_DATA_W-1:0] cfg_data = '0;

  always #4 clk = ~clk;

  binary_interior_pixel_removal_core dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),    // [7:0] pixel_value
    .in_tuser   (in_tuser),    // [0] flush
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),   // [7:0] out_value
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // Predictor state. The register copies hold the raw written values; the clamping
  // of width and height happens where they are used, as in the core.
  logic [bipr_pkg::FW_W-1:0]  width_reg = bipr_pkg::FRAME_WIDTH_RST;
  logic [bipr_pkg::FH_W-1:0]  height_reg = bipr_pkg::FRAME_HEIGHT_RST;
  logic [bipr_pkg::PIX_W-1:0] thresh_reg = bipr_pkg::LEVEL_THRESHOLD_RST;
  logic [7:0]       older_row [LINE_DEPTH];
  logic [7:0]       newer_row [LINE_DEPTH];
  logic [7:0]       win [3][3];
  int unsigned      col_pos = 0;
  int unsigned      row_pos = 0;

  // Boundary pixels predicted but not yet seen on the output, oldest first.
  bipr_pkg::result_t pending_boundary[$];

  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  // Both sides stop idling while this is set.
  bit          steady = 1'b0;
  // Set by a test to start the result side's hold-off, counted down in hold_left.
  bit          hold_req = 1'b0;
  int unsigned hold_left = 0;

  initial begin
    for (int i = 0; i < LINE_DEPTH; i++) begin
      older_row[i] = '0;
      newer_row[i] = '0;
    end
    for (int r = 0; r < 3; r++)
      for (int c = 0; c < 3; c++)
        win[r][c] = '0;
  end

  function automatic int unsigned eff_width();
    if (width_reg < 3) return 3;
    if (width_reg > LINE_DEPTH) return LINE_DEPTH;
    return width_reg;
  endfunction

  function automatic int unsigned eff_height();
    return (height_reg < 3) ? 3 : height_reg;
  endfunction

  // Advances the predictor by one accepted input word and queues the boundary pixel
  // that this word completes, if any. The window holds rows y-2, y-1 and y; its
  // center trails the input by one line plus one pixel.
  function automatic void extract_boundary_pixel(logic [7:0] pix_in, logic is_flush);
    int unsigned w;
    int unsigned h;
    int unsigned x;
    int unsigned y;
    int          cr;
    int          cc;
    int          rr;
    int          cl;
    logic [7:0]  px;
    logic        all_bright;
    bipr_pkg::result_t res;
    w  = eff_width();
    h  = eff_height();
    px = is_flush ? 8'd0 : pix_in;
    x  = col_pos;
    y  = row_pos;
    // A width that shrank under the running position wraps to the next row.
    if (x >= w) begin
      x = 0;
      y++;
    end
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = older_row[x];
    win[1][2] = newer_row[x];
    win[2][2] = px;
    older_row[x] = newer_row[x];
    newer_row[x] = px;
    if (x >= 1) begin
      cr = int'(y) - 1;
      cc = int'(x) - 1;
    end else begin
      cr = int'(y) - 2;
      cc = int'(w) - 1;
    end
    x++;
    if (x >= w) begin
      x = 0;
      y++;
    end
    // Past the drain rows the frame restarts without a result.
    if (y > h + 1) begin
      x = 0;
      y = 0;
    end
    col_pos = x;
    row_pos = y;
    if (cr < 0 || cr >= int'(h)) return;
    res.value = win[1][1];
    res.last  = (cr == int'(h) - 1) && (cc == int'(w) - 1);
    if (win[1][1] > thresh_reg) begin
      all_bright = 1'b1;
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          rr = cr + r - 1;
          cl = cc + c - 1;
          if (rr >= 0 && rr < int'(h) && cl >= 0 && cl < int'(w) && win[r][c] < thresh_reg)
            all_bright = 1'b0;
        end
      end
      if (all_bright) res.value = '0;
    end
    pending_boundary.insert(pending_boundary.size(), res);
    if (res.last) begin
      col_pos = 0;
      row_pos = 0;
    end
  endfunction

  // Pixel values cluster around full scale, zero and the threshold so that bright
  // regions with interior points, and values just either side of the limit, are common.
  function automatic logic [7:0] pick_pixel();
    case ($urandom_range(9))
      0, 1, 2, 3: return 8'hFF;
      4, 5:       return 8'h00;
      6:          return thresh_reg;
      7:          return thresh_reg - 8'd1;
      8:          return thresh_reg + 8'd1;
      default:    return 8'($urandom());
    endcase
  endfunction

  // Offers one word on the input stream and waits until the core takes it. It is
  // always entered at a rising edge; in_tvalid stays high when the next word follows
  // without a gap, so it never gets two assignments in one step.
  task automatic send_word(logic [7:0] pix, logic is_flush);
    while (!steady && $urandom_range(99) < 36) begin
      in_tvalid <= 1'b0;
      @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pix;
    in_tuser  <= is_flush;
    do @(posedge clk); while (!in_tready);
    extract_boundary_pixel(pix, is_flush);
  endtask

  // Feeds flush words until the predicted position is back at the start of a frame.
  // With pixel_words set the tail is drained with ordinary pixels instead.
  task automatic drain_frame(bit pixel_words);
    while (col_pos != 0 || row_pos != 0)
      send_word(pick_pixel(), !pixel_words);
  endtask

  // Sends one frame of random pixels at the current setting (the first cut words if cut
  // is nonzero), drained at the end. A fraction of the words sent are flush words.
  task automatic send_frame(int unsigned cut, bit pixel_tail, output int unsigned sent);
    int unsigned total;
    total = eff_width() * eff_height();
    if (cut != 0 && cut < total) total = cut;
    sent = total;
    for (int unsigned i = 0; i < total; i++)
      send_word(pick_pixel(), $urandom_range(15) == 0);
    sent += eff_width() + 1;
    drain_frame(pixel_tail);
  endtask

  // Lets every predicted result arrive and the pipeline settle before the
  // configuration changes.
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (pending_boundary.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Writes all three registers on consecutive edges and mirrors them in the predictor.
  task automatic program_frame(int unsigned width, int unsigned height, int unsigned thresh);
    cfg_we    <= 1'b1;
    cfg_index <= bipr_pkg::REG_FRAME_WIDTH;
    cfg_data  <= bipr_pkg::CFG_DATA_W'(width & 32'h7FF);
    @(posedge clk);
    cfg_index <= bipr_pkg::REG_FRAME_HEIGHT;
    cfg_data  <= bipr_pkg::CFG_DATA_W'(height & 32'h1FFF);
    @(posedge clk);
    cfg_index <= bipr_pkg::REG_LEVEL_THRESHOLD;
    cfg_data  <= bipr_pkg::CFG_DATA_W'(thresh & 32'hFF);
    @(posedge clk);
    cfg_we <= 1'b0;
    width_reg  = bipr_pkg::FW_W'(width);
    height_reg = bipr_pkg::FH_W'(height);
    thresh_reg = bipr_pkg::PIX_W'(thresh);
  endtask

  // Result side: random stalls, the long hold-off on request, and the field check of
  // every accepted result word against the oldest prediction.
  always @(posedge clk) begin
    bipr_pkg::result_t want;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        if (pending_boundary.size() == 0) begin
          error_count++;
          if (error_count <= MAX_REPORTS)
            $display("unexpected result word: value %0d last %0b", out_tdata, out_tlast);
        end else begin
          want = pending_boundary.pop_front();
          if (out_tdata !== want.value || out_tlast !== want.last) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
              $display("mismatch: expected value %0d last %0b, got value %0d last %0b",
                       want.value, want.last, out_tdata, out_tlast);
          end
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_tready <= 1'b0;
      end else begin
        out_tready <= steady || ($urandom_range(99) >= 36);
      end
    end
  end

  // Hard stop in case the core hangs.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("*** FAILED ***");
      $finish;
    end
  end

  // A bright pixel whose neighbors all reach the threshold is cleared, a pixel equal
  // to the threshold counts as bright for the neighbors but is never cleared itself,
  // and a flush word inside the frame acts as a dark pixel even with a bright value.
  task automatic test_window_rules();
    program_frame(3, 3, 128);
    send_word(8'd128, 1'b0);
    send_word(8'd200, 1'b0);
    send_word(8'd255, 1'b0);
    send_word(8'd255, 1'b0);
    send_word(8'd255, 1'b0);
    send_word(8'd129, 1'b0);
    send_word(8'hFF,  1'b1);
    send_word(8'd128, 1'b0);
    send_word(8'd255, 1'b0);
    drain_frame(1'b0);
    wait_idle();
  endtask

  // Undersized registers clamp to a 3x3 frame. With a zero threshold every nonzero
  // pixel is interior, and the tail is drained with plain pixels instead of flush words.
  task automatic test_clamp_and_zero_threshold();
    program_frame(2, 1, 0);
    send_word(8'd0,   1'b0);
    send_word(8'd1,   1'b0);
    send_word(8'd255, 1'b0);
    send_word(8'd128, 1'b0);
    send_word(8'd1,   1'b0);
    send_word(8'd0,   1'b0);
    send_word(8'd255, 1'b0);
    send_word(8'd255, 1'b0);
    send_word(8'd254, 1'b0);
    send_word(8'hAA,  1'b0);
    send_word(8'h55,  1'b0);
    send_word(8'hFF,  1'b0);
    send_word(8'h01,  1'b0);
    wait_idle();
  endtask

  // Geometry changed with a frame half done: a narrower width makes the running
  // column wrap to the next row, and a lower height leaves the position past the
  // drain rows so that the frame restarts with no result.
  task automatic test_midframe_changes();
    int unsigned sent;
    program_frame(8, 6, 200);
    for (int i = 0; i < 22; i++) send_word(pick_pixel(), 1'b0);
    wait_idle();
    program_frame(5, 3, 200);
    drain_frame(1'b0);
    wait_idle();
    program_frame(6, 8, 100);
    for (int i = 0; i < 36; i++) send_word(pick_pixel(), 1'b0);
    wait_idle();
    program_frame(6, 3, 100);
    send_word(pick_pixel(), 1'b0);
    send_frame(0, 1'b0, sent);
    wait_idle();
  endtask

  // The result side stops for a long time while the input keeps offering words
  // back to back, so the core fills up and has to hold its input off.
  task automatic test_output_stall();
    int unsigned sent;
    program_frame(12, 8, 200);
    steady   = 1'b1;
    hold_req = 1'b1;
    send_frame(0, 1'b0, sent);
    wait_idle();
    steady = 1'b0;
  endtask

  // Largest sizes: an oversized width that clamps to the full line buffer, continued
  // at the exact maximum width until every line buffer address has been written, then
  // narrowed so the running column wraps and the frame drains quickly. The tallest
  // height the register holds is started and then cut off by a lower height. The
  // wide part runs with no idling on either side.
  task automatic test_size_extremes();
    steady = 1'b1;
    program_frame(2047, 3, 255);
    for (int i = 0; i < 24; i++) send_word(pick_pixel(), 1'b0);
    wait_idle();
    program_frame(1024, 3, 250);
    for (int i = 24; i < LINE_DEPTH + 8; i++) send_word(pick_pixel(), 1'b0);
    wait_idle();
    steady = 1'b0;
    program_frame(5, 3, 250);
    drain_frame(1'b0);
    wait_idle();
    program_frame(0, 8191, 1);
    for (int i = 0; i < 40; i++) send_word(pick_pixel(), 1'b0);
    wait_idle();
    program_frame(3, 3, 1);
    drain_frame(1'b0);
    wait_idle();
  endtask

  // Mostly small well-formed frames with random settings, some sent back to back
  // without reprogramming, some cut short and padded out with flush or pixel words.
  task automatic test_random_frames();
    int unsigned words;
    int unsigned sent;
    int unsigned width;
    int unsigned height;
    int unsigned thresh;
    int unsigned cut;
    words = 0;
    while (words < RANDOM_WORDS) begin
      if ($urandom_range(4) != 0) begin
        case ($urandom_range(15))
          0:       width = $urandom_range(0, 2);
          1:       width = $urandom_range(13, 24);
          default: width = $urandom_range(3, 12);
        endcase
        height = ($urandom_range(15) == 0) ? $urandom_range(0, 2) : $urandom_range(3, 8);
        case ($urandom_range(7))
          0:       thresh = 0;
          1:       thresh = 255;
          default: thresh = $urandom_range(1, 254);
        endcase
        wait_idle();
        program_frame(width, height, thresh);
      end
      cut = ($urandom_range(9) == 0) ? $urandom_range(1, eff_width() * eff_height()) : 0;
      send_frame(cut, $urandom_range(3) == 0, sent);
      words += sent;
    end
    wait_idle();
  endtask

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_window_rules();
    test_clamp_and_zero_threshold();
    test_midframe_changes();
    test_output_stall();
    test_random_frames();
    test_size_extremes();
    wait_idle();
    if (pending_boundary.size() != 0) error_count++;
    if (error_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("failures: %0d", error_count);
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

>>> files.f
+incdir+rtl
rtl/bipr_pkg.sv
rtl/bipr_ram.sv
rtl/binary_interior_pixel_removal_core.sv
tb/tb_binary_interior_pixel_removal_core.sv
